// ===== src/ptt_pkg.sv =====
// Shared types and constants of the periodic task timer table.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int TIME_W = 48;
    localparam int PER_W  = 32;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [PER_W-1:0]  period_t;

    // Action codes of an input transaction.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SCHED   = 2'd1;
    localparam logic [1:0] ACT_UNSCHED = 2'd2;

    // Kind codes of a result transaction.
    localparam logic [1:0] KIND_SCHED   = 2'd0;
    localparam logic [1:0] KIND_UNSCHED = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;

    // Shortest repeat interval and the granularity of all intervals.
    localparam period_t MIN_PERIOD = 32'd10;

    // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 29;

    // Operations of the shared time adder.
    typedef logic alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

    // Write enables of the slot memory.
    typedef struct packed {
        logic due_we;
        logic per_we;
    } mem_wr_t;

endpackage

// ===== src/ptt_alu.sv =====
// Shared 48-bit time adder with an age comparator.
`timescale 1ns / 1ps

module ptt_alu (
    input  ptt_pkg::alu_op_t op,
    input  ptt_pkg::time_t   a,
    input  ptt_pkg::time_t   b,
    input  ptt_pkg::time_t   best_age,
    output ptt_pkg::time_t   res,
    output logic             older
);
    import ptt_pkg::*;

    // Times wrap modulo 2^48, so the carry out is simply dropped.
    assign res   = (op == ALU_SUB) ? (a - b) : (a + b);
    assign older = (res > best_age);

endmodule

// ===== src/ptt_norm.sv =====
// Repeat interval normalisation: zero stays zero, short values become ten,
// anything else is rounded down to a multiple of ten.
`timescale 1ns / 1ps

module ptt_norm (
    input  logic             clk,
    input  logic             load,
    input  ptt_pkg::period_t req,
    output ptt_pkg::period_t period
);
    import ptt_pkg::*;

    logic [63:0]       prod;
    logic [QUOT_W-1:0] quot_reg;
    period_t           times_ten;

    // Division by ten through the reciprocal; the quotient is registered
    // before it is scaled back up.
    assign prod = {32'd0, req} * {32'd0, RECIP_TEN};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg <= prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign times_ten = {quot_reg, 3'b000} + {2'b00, quot_reg, 1'b0};

    always_comb
    begin
        if (req == '0)
        begin
            period = '0;
        end
        else if (req < MIN_PERIOD)
        begin
            period = MIN_PERIOD;
        end
        else
        begin
            period = times_ten;
        end
    end

endmodule

// ===== src/ptt_mem.sv =====
// Slot memory holding the due time and the repeat interval of every slot.
`timescale 1ns / 1ps

module ptt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              clk,
    input  ptt_pkg::mem_wr_t  wr,
    input  logic [AW-1:0]     waddr,
    input  ptt_pkg::time_t    due_d,
    input  ptt_pkg::period_t  per_d,
    input  logic [AW-1:0]     raddr,
    output ptt_pkg::time_t    due_q,
    output ptt_pkg::period_t  per_q
);
    import ptt_pkg::*;

    time_t   due_mem [DEPTH];
    period_t per_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.due_we)
        begin
            due_mem[waddr] <= due_d;
        end
        if (wr.per_we)
        begin
            per_mem[waddr] <= per_d;
        end
        due_q <= due_mem[raddr];
        per_q <= per_mem[raddr];
    end

endmodule

// ===== src/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: sequencer, slot marks and clock.
`timescale 1ns / 1ps

// Usage
// A transaction is taken at a rising edge where start is high and busy is low;
// action selects a one-millisecond tick, a schedule or an unschedule of slot.
// Each result appears for exactly one cycle with result_strobe high, carrying
// kind, ok, slot_out and last; the receiver cannot stall, so results are never
// held back. last marks the final result caused by one input transaction.
// An unschedule or a refused schedule answers in the cycle after acceptance
// and busy never rises; an unused action code is dropped with no result and
// busy never rises either. An accepted schedule passes through S_NORM
// (normalise the interval) and S_SCHED (write the slot) before the reply, with
// busy high in both. A tick runs S_INC and then one pass over the table, or
// one pass for each slot that falls due: every pass reads the slot memory once
// per slot through its single read port, evaluates each age on the one shared
// 48-bit adder, and ends in the firing state S_FIRE. A tick with nothing due
// gives no result.
// Reset clears the millisecond clock, all active marks and the sequencer; the
// slot memory itself is not cleared, as a slot's contents are only used while active.

module periodic_task_timer_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            action,
    input  logic [3:0]            slot,
    input  logic [31:0]           repeat_interval,
    input  logic [31:0]           initial_delay,
    output logic                  result_strobe,
    output logic [1:0]            kind,
    output logic                  ok,
    output logic [3:0]            slot_out,
    output logic                  last
);
    import ptt_pkg::*;

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW = (SW > 4) ? SW : 4;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NORM  = 3'd1;
    localparam logic [2:0] S_SCHED = 3'd2;
    localparam logic [2:0] S_INC   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIRE  = 3'd5;

    logic [2:0]           state_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] pending_reg;
    logic [NUM_SLOTS-1:0] pending_next;
    time_t                now_reg;

    // Latched request.
    logic [SW-1:0]        slot_ix_reg;
    period_t              interval_reg;
    period_t              delay_reg;

    // Scan pipeline: read issue counter and evaluation stage.
    logic [CW-1:0]        rd_cnt_reg;
    logic                 ev_valid_reg;
    logic [SW-1:0]        ev_idx_reg;
    logic                 first_reg;

    // Best candidate of the current pass.
    logic                 found_reg;
    logic [SW-1:0]        best_idx_reg;
    time_t                best_age_reg;
    time_t                best_due_reg;
    period_t              best_per_reg;

    // Result registers.
    logic                 strobe_reg;
    logic [1:0]           kind_reg;
    logic                 ok_reg;
    logic [3:0]           slot_out_reg;
    logic                 last_reg;

    logic [IW-1:0]        slot_ext;
    logic [SW-1:0]        slot_ix;
    logic                 in_range;
    logic                 accept;
    logic [IW-1:0]        best_ext;

    alu_op_t              alu_op;
    time_t                alu_a;
    time_t                alu_b;
    time_t                alu_res;
    logic                 alu_older;

    mem_wr_t              mem_wr;
    logic [SW-1:0]        mem_waddr;
    time_t                due_q;
    period_t              per_q;
    period_t              norm_period;

    logic                 cand;
    logic                 is_due;
    logic                 take;
    logic                 pass_end;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign slot_ext = IW'(slot);
    assign slot_ix  = slot_ext[SW-1:0];
    assign in_range = (32'(slot) < 32'(NUM_SLOTS));
    assign best_ext = IW'(best_idx_reg);

    // The one adder serves the clock increment, the due time of a new slot,
    // the age of every slot during a scan and the move of a repeating slot.
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = now_reg;
        alu_b  = time_t'(1);
        unique case (state_reg)
            S_SCHED:
            begin
                alu_b = time_t'(delay_reg);
            end
            S_SCAN:
            begin
                alu_op = ALU_SUB;
                alu_b  = due_q;
            end
            S_FIRE:
            begin
                alu_a = best_due_reg;
                alu_b = time_t'(best_per_reg);
            end
            default:
            begin
                alu_b = time_t'(1);
            end
        endcase
    end

    ptt_alu u_alu (
        .op       (alu_op),
        .a        (alu_a),
        .b        (alu_b),
        .best_age (best_age_reg),
        .res      (alu_res),
        .older    (alu_older)
    );

    ptt_norm u_norm (
        .clk    (clk),
        .load   (state_reg == S_NORM),
        .req    (interval_reg),
        .period (norm_period)
    );

    // A repeating slot is written at its new due time; a new slot gets both.
    always_comb
    begin
        mem_wr.due_we = (state_reg == S_SCHED) ||
                        ((state_reg == S_FIRE) && found_reg && (best_per_reg != '0));
        mem_wr.per_we = (state_reg == S_SCHED);
        mem_waddr     = (state_reg == S_SCHED) ? slot_ix_reg : best_idx_reg;
    end

    ptt_mem #(
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .waddr (mem_waddr),
        .due_d (alu_res),
        .per_d (norm_period),
        .raddr (rd_cnt_reg[SW-1:0]),
        .due_q (due_q),
        .per_q (per_q)
    );

    // Evaluation of one slot: on the first pass the due set is built from the
    // active marks; later passes only look at slots still pending. The due set
    // is frozen by the first pass, so a moved slot never fires twice per tick.
    assign cand     = first_reg ? active_reg[ev_idx_reg] : pending_reg[ev_idx_reg];
    assign is_due   = ev_valid_reg && cand && !alu_res[TIME_W-1];
    assign take     = is_due && (!found_reg || alu_older);
    assign pass_end = ev_valid_reg && (ev_idx_reg == SW'(NUM_SLOTS - 1));

    always_comb
    begin
        pending_next = pending_reg;
        pending_next[best_idx_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            pending_reg  <= '0;
            now_reg      <= '0;
            rd_cnt_reg   <= '0;
            ev_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            found_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        slot_ix_reg  <= slot_ix;
                        interval_reg <= repeat_interval;
                        delay_reg    <= initial_delay;
                        slot_out_reg <= slot;
                        last_reg     <= 1'b1;
                        unique case (action)
                            ACT_TICK:
                            begin
                                state_reg <= S_INC;
                            end
                            ACT_SCHED:
                            begin
                                kind_reg <= KIND_SCHED;
                                if (in_range && !active_reg[slot_ix])
                                begin
                                    state_reg <= S_NORM;
                                end
                                else
                                begin
                                    ok_reg     <= 1'b0;
                                    strobe_reg <= 1'b1;
                                end
                            end
                            ACT_UNSCHED:
                            begin
                                kind_reg   <= KIND_UNSCHED;
                                strobe_reg <= 1'b1;
                                if (in_range && active_reg[slot_ix])
                                begin
                                    ok_reg              <= 1'b1;
                                    active_reg[slot_ix] <= 1'b0;
                                end
                                else
                                begin
                                    ok_reg <= 1'b0;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_NORM:
                begin
                    state_reg <= S_SCHED;
                end
                S_SCHED:
                begin
                    active_reg[slot_ix_reg] <= 1'b1;
                    ok_reg                  <= 1'b1;
                    strobe_reg              <= 1'b1;
                    state_reg               <= S_IDLE;
                end
                S_INC:
                begin
                    now_reg      <= alu_res;
                    rd_cnt_reg   <= '0;
                    ev_valid_reg <= 1'b0;
                    first_reg    <= 1'b1;
                    found_reg    <= 1'b0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (rd_cnt_reg < CW'(NUM_SLOTS))
                    begin
                        rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    end
                    ev_valid_reg <= (rd_cnt_reg < CW'(NUM_SLOTS));
                    ev_idx_reg   <= rd_cnt_reg[SW-1:0];
                    if (ev_valid_reg && first_reg)
                    begin
                        pending_reg[ev_idx_reg] <= is_due;
                    end
                    if (take)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= ev_idx_reg;
                        best_age_reg <= alu_res;
                        best_due_reg <= due_q;
                        best_per_reg <= per_q;
                    end
                    if (pass_end)
                    begin
                        state_reg <= S_FIRE;
                    end
                end
                S_FIRE:
                begin
                    if (!found_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (best_per_reg == '0)
                        begin
                            active_reg[best_idx_reg] <= 1'b0;
                        end
                        pending_reg  <= pending_next;
                        strobe_reg   <= 1'b1;
                        kind_reg     <= KIND_FIRED;
                        ok_reg       <= 1'b1;
                        slot_out_reg <= best_ext[3:0];
                        last_reg     <= (pending_next == '0);
                        rd_cnt_reg   <= '0;
                        ev_valid_reg <= 1'b0;
                        first_reg    <= 1'b0;
                        found_reg    <= 1'b0;
                        state_reg    <= (pending_next == '0) ? S_IDLE : S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign ok            = ok_reg;
    assign slot_out      = slot_out_reg;
    assign last          = last_reg;

`ifndef SYNTH
    // Only active slots can be waiting to fire.
    a_pending_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~active_reg) == '0)
        else $error("pending slot is not active");

    // Nothing is left waiting once the block is ready again.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (pending_reg == '0))
        else $error("pending slots left while idle");

    // A reply to a schedule or unschedule is always the only result.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (kind != KIND_FIRED)) |-> last)
        else $error("reply not marked last");

    // A fired task is always reported as accepted.
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (kind == KIND_FIRED)) |-> ok)
        else $error("fired result without ok");

    // A result marked last is not followed at once by a firing.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !(result_strobe && (kind == KIND_FIRED)))
        else $error("firing directly after last result");
`endif

endmodule
